### hw/rtl/cpu8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared types, operation codes, flag bit positions and decimal adjust constants for the 8-bit ALU.
// ----------------------------------------------------------------------------
package cpu8_pkg;

    // Operation codes.
    localparam logic [3:0] OP_INC   = 4'd0;
    localparam logic [3:0] OP_DEC   = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_ADC   = 4'd3;
    localparam logic [3:0] OP_RLCA  = 4'd4;
    localparam logic [3:0] OP_RRCA  = 4'd5;
    localparam logic [3:0] OP_RLA   = 4'd6;
    localparam logic [3:0] OP_RRA   = 4'd7;
    localparam logic [3:0] OP_DAA   = 4'd8;
    localparam logic [3:0] OP_CPL   = 4'd9;
    localparam logic [3:0] OP_SCF   = 4'd10;
    localparam logic [3:0] OP_CCF   = 4'd11;
    localparam logic [3:0] OP_ADD16 = 4'd12;

    // Flag bit positions: S Z 5 H 3 PV N C.
    localparam int FL_S  = 7;
    localparam int FL_Z  = 6;
    localparam int FL_5  = 5;
    localparam int FL_H  = 4;
    localparam int FL_3  = 3;
    localparam int FL_PV = 2;
    localparam int FL_N  = 1;
    localparam int FL_C  = 0;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LO_CORR = 8'h06;
    localparam logic [7:0] DAA_HI_CORR = 8'h60;

    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] first_operand;
        logic [15:0] second_operand;
        logic [7:0]  flags_in;
    } req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  flags_out;
    } rsp_t;

endpackage

### hw/rtl/cpu8_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_core
// Combinational datapath: computes the result and the new flag byte for one
// operation.
// ----------------------------------------------------------------------------
module cpu8_alu_core (
    input  cpu8_pkg::req_t req,
    output cpu8_pkg::rsp_t rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        c_add;
    logic [8:0]  sum8;
    logic [4:0]  half8;
    logic [16:0] sum16;
    logic [12:0] half16;
    logic [3:0]  lo;
    logic        lo_gt9;
    logic [7:0]  corr;
    logic        daa_c;
    logic [7:0]  r;
    logic [15:0] res;
    logic [7:0]  f;

    assign a      = req.first_operand[7:0];
    assign b      = req.second_operand[7:0];
    assign cin    = req.flags_in[cpu8_pkg::FL_C];
    assign c_add  = (req.op == cpu8_pkg::OP_ADC) ? cin : 1'b0;
    assign sum8   = {1'b0, a} + {1'b0, b} + {8'h00, c_add};
    assign half8  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c_add};
    assign sum16  = {1'b0, req.first_operand} + {1'b0, req.second_operand};
    assign half16 = {1'b0, req.first_operand[11:0]} + {1'b0, req.second_operand[11:0]};
    assign lo     = a[3:0];
    assign lo_gt9 = (lo > 4'd9);
    assign daa_c  = cin || (a > 8'h99);
    assign corr   = ((lo_gt9 || req.flags_in[cpu8_pkg::FL_H]) ? cpu8_pkg::DAA_LO_CORR : 8'h00)
                  | (daa_c ? cpu8_pkg::DAA_HI_CORR : 8'h00);

    always_comb
    begin
        r   = a;
        f   = req.flags_in;
        res = 16'h0000;
        unique case (req.op)
            cpu8_pkg::OP_INC:
            begin
                r = a + 8'd1;
                f[cpu8_pkg::FL_H]  = (lo == 4'hF);
                f[cpu8_pkg::FL_PV] = (a == 8'h7F);
                f[cpu8_pkg::FL_N]  = 1'b0;
            end
            cpu8_pkg::OP_DEC:
            begin
                r = a - 8'd1;
                f[cpu8_pkg::FL_H]  = (lo == 4'h0);
                f[cpu8_pkg::FL_PV] = (a == 8'h80);
                f[cpu8_pkg::FL_N]  = 1'b1;
            end
            cpu8_pkg::OP_ADD, cpu8_pkg::OP_ADC:
            begin
                r = sum8[7:0];
                f[cpu8_pkg::FL_H]  = half8[4];
                f[cpu8_pkg::FL_PV] = ~(a[7] ^ b[7]) & (a[7] ^ sum8[7]);
                f[cpu8_pkg::FL_N]  = 1'b0;
                f[cpu8_pkg::FL_C]  = sum8[8];
            end
            cpu8_pkg::OP_RLCA:
            begin
                r = {a[6:0], a[7]};
                f[cpu8_pkg::FL_C] = a[7];
                f[cpu8_pkg::FL_H] = 1'b0;
                f[cpu8_pkg::FL_N] = 1'b0;
            end
            cpu8_pkg::OP_RRCA:
            begin
                r = {a[0], a[7:1]};
                f[cpu8_pkg::FL_C] = a[0];
                f[cpu8_pkg::FL_H] = 1'b0;
                f[cpu8_pkg::FL_N] = 1'b0;
            end
            cpu8_pkg::OP_RLA:
            begin
                r = {a[6:0], cin};
                f[cpu8_pkg::FL_C] = a[7];
                f[cpu8_pkg::FL_H] = 1'b0;
                f[cpu8_pkg::FL_N] = 1'b0;
            end
            cpu8_pkg::OP_RRA:
            begin
                r = {cin, a[7:1]};
                f[cpu8_pkg::FL_C] = a[0];
                f[cpu8_pkg::FL_H] = 1'b0;
                f[cpu8_pkg::FL_N] = 1'b0;
            end
            cpu8_pkg::OP_DAA:
            begin
                // After a subtraction the correction is taken away instead of added.
                if (req.flags_in[cpu8_pkg::FL_N])
                begin
                    r = a - corr;
                    f[cpu8_pkg::FL_H] = req.flags_in[cpu8_pkg::FL_H] && (lo < 4'd6);
                end
                else
                begin
                    r = a + corr;
                    f[cpu8_pkg::FL_H] = lo_gt9;
                end
                f[cpu8_pkg::FL_PV] = ~(^r);
                f[cpu8_pkg::FL_C]  = daa_c;
            end
            cpu8_pkg::OP_CPL:
            begin
                r = ~a;
                f[cpu8_pkg::FL_H] = 1'b1;
                f[cpu8_pkg::FL_N] = 1'b1;
            end
            cpu8_pkg::OP_SCF:
            begin
                f[cpu8_pkg::FL_C] = 1'b1;
                f[cpu8_pkg::FL_H] = 1'b0;
                f[cpu8_pkg::FL_N] = 1'b0;
            end
            cpu8_pkg::OP_CCF:
            begin
                f[cpu8_pkg::FL_H] = cin;
                f[cpu8_pkg::FL_C] = ~cin;
                f[cpu8_pkg::FL_N] = 1'b0;
            end
            cpu8_pkg::OP_ADD16:
            begin
                f[cpu8_pkg::FL_H] = half16[12];
                f[cpu8_pkg::FL_N] = 1'b0;
                f[cpu8_pkg::FL_C] = sum16[16];
            end
            default:
            begin
                r = a;
            end
        endcase

        // Sign and zero follow the 8-bit result for inc, dec, add, adc and daa.
        if ((req.op == cpu8_pkg::OP_INC) || (req.op == cpu8_pkg::OP_DEC) ||
            (req.op == cpu8_pkg::OP_ADD) || (req.op == cpu8_pkg::OP_ADC) ||
            (req.op == cpu8_pkg::OP_DAA))
        begin
            f[cpu8_pkg::FL_S] = r[7];
            f[cpu8_pkg::FL_Z] = (r == 8'h00);
        end

        if (req.op == cpu8_pkg::OP_ADD16)
        begin
            res = sum16[15:0];
        end
        else
        begin
            res = {8'h00, r};
        end
    end

    assign rsp.result    = res;
    assign rsp.flags_out = f;

endmodule

### hw/rtl/cpu8_alu_with_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags
// 8-bit ALU with flag generation for a small CPU core.
// ----------------------------------------------------------------------------
// Usage:
// An operation enters on the req channel (req_valid, req_stall, req) and its
// result leaves on the rsp channel (rsp_valid, rsp_stall, rsp). A transfer
// happens at a rising edge where valid is high and stall is low.
// Each operation first lands in an input register (s1_reg); the ALU datapath
// then works between that register and the result register (s2_reg), which
// offers the result. While the receiver does not hold rsp_stall, a new request
// can transfer on every cycle, so the throughput is one operation per cycle.
// When the receiver holds rsp_stall, the result register keeps its value and
// the input register fills; req_stall rises once both stages are occupied.
// Reset empties both stages: rsp_valid is low and req_stall is low
// afterward. There is no configuration and no state kept between operations.
// ----------------------------------------------------------------------------
module cpu8_alu_with_flags (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cpu8_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cpu8_pkg::rsp_t rsp
);

    logic           s1_valid_reg;
    logic           s1_valid_next;
    cpu8_pkg::req_t s1_reg;
    logic           s2_valid_reg;
    logic           s2_valid_next;
    cpu8_pkg::rsp_t s2_reg;
    cpu8_pkg::rsp_t alu_rsp;
    logic           s1_ready;
    logic           s2_ready;
    logic           s1_load;
    logic           s2_load;

    cpu8_alu_core u_core (
        .req (s1_reg),
        .rsp (alu_rsp)
    );

    assign s2_ready      = !s2_valid_reg || !rsp_stall;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s1_load       = req_valid && s1_ready;
    assign s2_load       = s1_valid_reg && s2_ready;
    assign s1_valid_next = s1_ready ? req_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= req;
        end
        if (s2_load)
        begin
            s2_reg <= alu_rsp;
        end
    end

    assign req_stall = !s1_ready;
    assign rsp_valid = s2_valid_reg;
    assign rsp       = s2_reg;

`ifndef ASSERT_OFF
    // A request transfer always leaves the input stage occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> s1_valid_reg)
        else $error("input stage empty after a request transfer");

    // An occupied input stage moving forward always produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> rsp_valid)
        else $error("result missing after the input stage advanced");

    // Flag bits 5 and 3 are never touched by any operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> ((rsp.flags_out[cpu8_pkg::FL_5] == $past(s1_reg.flags_in[cpu8_pkg::FL_5]))
                  && (rsp.flags_out[cpu8_pkg::FL_3] == $past(s1_reg.flags_in[cpu8_pkg::FL_3]))))
        else $error("flag bit 5 or 3 changed");

    // Only the 16-bit add may drive the upper result byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> (($past(s1_reg.op) == cpu8_pkg::OP_ADD16) || (rsp.result[15:8] == 8'h00)))
        else $error("upper result byte set by an 8-bit operation");
`endif

endmodule

### bench/cpu8_alu_with_flags_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags_tb
// Self-checking bench for the flag ALU. Every operation that transfers on the
// request side is run through a local flag predictor, and the results that
// transfer on the response side are compared in order, result and flags
// separately. The stimulus covers corner operands of every operation, then
// random traffic with bursty gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module cpu8_alu_with_flags_tb;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 1850;
    localparam int          PHASES       = 6;
    localparam int          LONG_HOLD    = 64;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          LIMIT_CYCLES = 600000;
    // Codes with no operation behind them; the block passes the low byte of A and the flags.
    localparam logic [3:0]  OP_SPARE_LO  = 4'd13;
    localparam logic [3:0]  OP_SPARE_HI  = 4'd15;

    typedef struct packed {
        cpu8_pkg::req_t request;
        cpu8_pkg::rsp_t response;
    } alu_case_t;

    class alu_scoreboard;
        alu_case_t expected_q[$];
        int        errors;
        int        checked;
        int        noted;

        function new();
            errors  = 0;
            checked = 0;
            noted   = 0;
        endfunction

        function cpu8_pkg::rsp_t predict(cpu8_pkg::req_t q);
            logic [7:0]  a;
            logic [7:0]  b;
            logic [7:0]  r8;
            logic [7:0]  fl;
            logic [7:0]  corr;
            logic [8:0]  sum9;
            logic [4:0]  half5;
            logic [16:0] sum17;
            logic [12:0] half13;
            logic        cin;
            logic        carry_add;
            logic        lo_over9;
            logic        daa_carry;
            logic        daa_half;
            logic        set_sz;
            cpu8_pkg::rsp_t o;
            a        = q.first_operand[7:0];
            b        = q.second_operand[7:0];
            fl       = q.flags_in;
            cin      = fl[cpu8_pkg::FL_C];
            r8       = a;
            set_sz   = 1'b0;
            sum17    = '0;
            case (q.op)
                cpu8_pkg::OP_INC:
                begin
                    r8                  = a + 8'd1;
                    set_sz              = 1'b1;
                    fl[cpu8_pkg::FL_H]  = (a[3:0] == 4'hF);
                    fl[cpu8_pkg::FL_PV] = (a == 8'h7F);
                    fl[cpu8_pkg::FL_N]  = 1'b0;
                end
                cpu8_pkg::OP_DEC:
                begin
                    r8                  = a - 8'd1;
                    set_sz              = 1'b1;
                    fl[cpu8_pkg::FL_H]  = (a[3:0] == 4'h0);
                    fl[cpu8_pkg::FL_PV] = (a == 8'h80);
                    fl[cpu8_pkg::FL_N]  = 1'b1;
                end
                cpu8_pkg::OP_ADD, cpu8_pkg::OP_ADC:
                begin
                    carry_add  = (q.op == cpu8_pkg::OP_ADC) ? cin : 1'b0;
                    sum9       = {1'b0, a} + {1'b0, b} + {8'd0, carry_add};
                    half5      = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_add};
                    r8         = sum9[7:0];
                    set_sz     = 1'b1;
                    fl[cpu8_pkg::FL_H]  = half5[4];
                    fl[cpu8_pkg::FL_PV] = (a[7] == b[7]) && (r8[7] != a[7]);
                    fl[cpu8_pkg::FL_N]  = 1'b0;
                    fl[cpu8_pkg::FL_C]  = sum9[8];
                end
                cpu8_pkg::OP_RLCA, cpu8_pkg::OP_RRCA, cpu8_pkg::OP_RLA, cpu8_pkg::OP_RRA:
                begin
                    case (q.op)
                        cpu8_pkg::OP_RLCA: r8 = {a[6:0], a[7]};
                        cpu8_pkg::OP_RRCA: r8 = {a[0], a[7:1]};
                        cpu8_pkg::OP_RLA:  r8 = {a[6:0], cin};
                        default:           r8 = {cin, a[7:1]};
                    endcase
                    fl[cpu8_pkg::FL_C] = (q.op == cpu8_pkg::OP_RLCA || q.op == cpu8_pkg::OP_RLA)
                                         ? a[7] : a[0];
                    fl[cpu8_pkg::FL_H] = 1'b0;
                    fl[cpu8_pkg::FL_N] = 1'b0;
                end
                cpu8_pkg::OP_DAA:
                begin
                    lo_over9  = (a[3:0] > 4'd9);
                    corr      = 8'h00;
                    if (lo_over9 || fl[cpu8_pkg::FL_H])
                        corr = corr | cpu8_pkg::DAA_LO_CORR;
                    daa_carry = cin || (a > 8'h99);
                    if (daa_carry)
                        corr = corr | cpu8_pkg::DAA_HI_CORR;
                    if (fl[cpu8_pkg::FL_N])
                    begin
                        r8       = a - corr;
                        daa_half = fl[cpu8_pkg::FL_H] && (a[3:0] < 4'd6);
                    end
                    else
                    begin
                        r8       = a + corr;
                        daa_half = lo_over9;
                    end
                    set_sz    = 1'b1;
                    fl[cpu8_pkg::FL_H]  = daa_half;
                    fl[cpu8_pkg::FL_PV] = ~^r8;
                    fl[cpu8_pkg::FL_C]  = daa_carry;
                end
                cpu8_pkg::OP_CPL:
                begin
                    r8       = ~a;
                    fl[cpu8_pkg::FL_H] = 1'b1;
                    fl[cpu8_pkg::FL_N] = 1'b1;
                end
                cpu8_pkg::OP_SCF:
                begin
                    fl[cpu8_pkg::FL_C] = 1'b1;
                    fl[cpu8_pkg::FL_H] = 1'b0;
                    fl[cpu8_pkg::FL_N] = 1'b0;
                end
                cpu8_pkg::OP_CCF:
                begin
                    fl[cpu8_pkg::FL_H] = cin;
                    fl[cpu8_pkg::FL_C] = ~cin;
                    fl[cpu8_pkg::FL_N] = 1'b0;
                end
                cpu8_pkg::OP_ADD16:
                begin
                    sum17    = {1'b0, q.first_operand} + {1'b0, q.second_operand};
                    half13   = {1'b0, q.first_operand[11:0]} + {1'b0, q.second_operand[11:0]};
                    fl[cpu8_pkg::FL_H] = half13[12];
                    fl[cpu8_pkg::FL_N] = 1'b0;
                    fl[cpu8_pkg::FL_C] = sum17[16];
                end
                default:
                begin
                end
            endcase
            if (set_sz)
            begin
                fl[cpu8_pkg::FL_S] = r8[7];
                fl[cpu8_pkg::FL_Z] = (r8 == 8'h00);
            end
            o.result    = (q.op == cpu8_pkg::OP_ADD16) ? sum17[15:0] : {8'h00, r8};
            o.flags_out = fl;
            return o;
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        function void note_request(cpu8_pkg::req_t q);
            alu_case_t c;
            c.request  = q;
            c.response = predict(q);
            expected_q.push_back(c);
            noted++;
        endfunction

        task check_result(cpu8_pkg::rsp_t got);
            alu_case_t c;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h flags %h with nothing pending",
                                          got.result, got.flags_out));
            end
            else
            begin
                c = expected_q.pop_front();
                checked++;
                if (got.result !== c.response.result)
                    report_mismatch($sformatf("op %0d a %h b %h f %h: result %h, expected %h",
                                              c.request.op, c.request.first_operand,
                                              c.request.second_operand, c.request.flags_in,
                                              got.result, c.response.result));
                if (got.flags_out !== c.response.flags_out)
                    report_mismatch($sformatf("op %0d a %h b %h f %h: flags %h, expected %h",
                                              c.request.op, c.request.first_operand,
                                              c.request.second_operand, c.request.flags_in,
                                              got.flags_out, c.response.flags_out));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    cpu8_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    cpu8_pkg::rsp_t rsp;

    alu_scoreboard sb;
    bit            tx_quiet;
    bit            rx_quiet;
    bit            long_hold_pending;
    int            cycle_count;

    cpu8_alu_with_flags i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic cpu8_pkg::req_t make_request(logic [3:0] op, logic [15:0] x,
                                                    logic [15:0] y, logic [7:0] f);
        cpu8_pkg::req_t q;
        q.op             = op;
        q.first_operand  = x;
        q.second_operand = y;
        q.flags_in       = f;
        return q;
    endfunction

    function automatic logic [7:0] corner_byte();
        case ($urandom_range(0, 6))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h0F;
            3:       return 8'h10;
            4:       return 8'h7F;
            5:       return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic cpu8_pkg::req_t random_request();
        cpu8_pkg::req_t q;
        int   pick;
        pick             = $urandom_range(0, 99);
        q.op             = (pick < 93)
                           ? 4'($urandom_range(cpu8_pkg::OP_INC, cpu8_pkg::OP_ADD16))
                           : 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        q.first_operand  = 16'($urandom());
        q.second_operand = 16'($urandom());
        q.flags_in       = 8'($urandom());
        pick             = $urandom_range(0, 99);
        if (q.op == cpu8_pkg::OP_DAA && pick < 50)
        begin
            // Valid BCD bytes for half of the daa operations, as left behind by a real add or subtract.
            q.first_operand[7:4] = 4'($urandom_range(0, 9));
            q.first_operand[3:0] = 4'($urandom_range(0, 9));
        end
        else if (pick < 20)
        begin
            q.first_operand[7:0]  = corner_byte();
            q.second_operand[7:0] = corner_byte();
        end
        return q;
    endfunction

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_quiet || pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold the operation on the bus until the block takes it.
    task automatic send_operation(cpu8_pkg::req_t q);
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= q;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        sb.note_request(q);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    task automatic wait_for_results();
        idle_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_operation(make_request(cpu8_pkg::OP_INC,   16'hA57F, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_INC,   16'h00FF, 16'hFFFF, 8'hFF));
        send_operation(make_request(cpu8_pkg::OP_INC,   16'h000F, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_DEC,   16'h0080, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_DEC,   16'hFF00, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_ADD,   16'h00FF, 16'h0001, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_ADD,   16'h007F, 16'h0001, 8'hFF));
        send_operation(make_request(cpu8_pkg::OP_ADD,   16'h0080, 16'h0080, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_ADC,   16'h000F, 16'h0000, 8'h01));
        send_operation(make_request(cpu8_pkg::OP_ADC,   16'h00FF, 16'h00FF, 8'hFF));
        send_operation(make_request(cpu8_pkg::OP_RLCA,  16'h0080, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_RRCA,  16'h0001, 16'h0000, 8'hFF));
        send_operation(make_request(cpu8_pkg::OP_RLA,   16'h0080, 16'h0000, 8'h01));
        send_operation(make_request(cpu8_pkg::OP_RRA,   16'h0001, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_DAA,   16'h009A, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_DAA,   16'h0015, 16'h0000, 8'h12));
        send_operation(make_request(cpu8_pkg::OP_DAA,   16'h0000, 16'h0000, 8'h01));
        send_operation(make_request(cpu8_pkg::OP_DAA,   16'h00FF, 16'h0000, 8'h02));
        send_operation(make_request(cpu8_pkg::OP_CPL,   16'hFF00, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_SCF,   16'h1234, 16'h0000, 8'h12));
        send_operation(make_request(cpu8_pkg::OP_CCF,   16'h0000, 16'h0000, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_CCF,   16'hFFFF, 16'hFFFF, 8'hFF));
        send_operation(make_request(cpu8_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 8'h00));
        send_operation(make_request(cpu8_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 8'hFF));
        send_operation(make_request(cpu8_pkg::OP_ADD16, 16'h8000, 16'h8000, 8'hFF));
        send_operation(make_request(OP_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'hA5));
        send_operation(make_request(OP_SPARE_HI, 16'h005A, 16'h0000, 8'h5A));
    endtask

    // Receiver: random stalls, a quiet mode, and one long hold on request.
    initial
    begin
        int stall_run;
        int pick;
        stall_run = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD - 1)
                    @(negedge clk);
                stall_run = 0;
            end
            else if (stall_run > 0)
            begin
                rsp_stall <= 1'b1;
                stall_run--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (rx_quiet || pick < 70)
                begin
                    rsp_stall <= 1'b0;
                end
                else
                begin
                    stall_run = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
                    rsp_stall <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
        $display("cpu8_alu_with_flags_tb: done, errors");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        sb                = new();
        tx_quiet          = 1'b0;
        rx_quiet          = 1'b0;
        long_hold_pending = 1'b0;
        rst_n             = 1'b0;
        req_valid         = 1'b0;
        req               = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_for_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Phase 1 runs back to back on both sides; phase 3 opens with a
            // burst against a receiver that holds off, so the pipe backs up.
            tx_quiet = (phase == 1) || (phase == 3);
            rx_quiet = (phase == 1);
            if (phase == 3)
                long_hold_pending = 1'b1;
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (phase == 3 && n == 40)
                    tx_quiet = 1'b0;
                if (phase == 4 && n == 150)
                    wait_for_results();
                send_operation(random_request());
                idle_sender(sender_gap());
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("cpu8_alu_with_flags_tb: %0d operations sent, %0d results compared, %0d errors",
                 sb.noted, sb.checked, sb.errors);
        $display("cpu8_alu_with_flags_tb: all opcodes incl. spare ones, corner operands, %s",
                 "bursty gaps and stalls, one long receiver hold, mid-run drains");
        if (sb.errors == 0)
            $display("cpu8_alu_with_flags_tb: done, clean");
        else
            $display("cpu8_alu_with_flags_tb: done, errors");
        $finish;
    end

endmodule

### cpu8_alu_with_flags.f
hw/rtl/cpu8_pkg.sv
hw/rtl/cpu8_alu_core.sv
hw/rtl/cpu8_alu_with_flags.sv
bench/cpu8_alu_with_flags_tb.sv
